### hdl/scp_pkg.sv
// Shared types, constants and helpers for the sine/cosine polynomial unit.
// No dependencies; used by every module under hdl/.
package scp_pkg;

   // Fixed-point formats of the ports
   localparam int ANGLE_FRAC_BITS = 27;
   localparam int OUT_FRAC_BITS   = 30;

   // Default depth of the front-to-back queue
   localparam int QUEUE_DEPTH = 4;

   // Folded angle width (Q.58 magnitude, at most 3pi)
   localparam int XW = 62;

   // Angle constants in Q.58
   localparam logic [63:0] PI58        = 64'd905502432259640355;
   localparam logic [63:0] HALFPI58    = 64'd452751216129820178;
   localparam logic [63:0] QUARTERPI58 = 64'd226375608064910089;
   localparam logic [63:0] TWOPI58     = 64'd1811004864519280711;
   localparam logic [63:0] THREEPI58   = 64'd2716507296778921066;

   // Polynomial coefficients and one, all in Q.62
   localparam logic signed [63:0] KC0   = 64'sd732731531;
   localparam logic signed [63:0] KC1   = -64'sd115525502583;
   localparam logic signed [63:0] KC2   = 64'sd12708567296624;
   localparam logic signed [63:0] KC3   = -64'sd915017066440997;
   localparam logic signed [63:0] KC4   = 64'sd38430716812455982;
   localparam logic signed [63:0] KC5   = -64'sd768614336404561593;
   localparam logic signed [63:0] ONE62 = 64'sd4611686018427387904;

   // Multiply chain: z, five Horner steps, the final Horner step, s, and 1 - s*s
   localparam int MUL_COUNT = 9;

   // Square root: 64 bit pairs, a few per pipeline stage
   localparam int SQRT_STEPS  = 2;
   localparam int SQRT_STAGES = 64 / SQRT_STEPS;

   // Symmetry flags picked up while folding
   typedef struct packed {
      logic swap;
      logic c_neg;
      logic s_neg;
   } scp_flags_type;

   // Partly folded angle inside the front part
   typedef struct packed {
      logic [XW-1:0] x;
      scp_flags_type flags;
   } scp_fold_type;

   // Item handed from the front part to the back part (t in Q.62)
   typedef struct packed {
      logic [63:0]   t;
      scp_flags_type flags;
   } scp_item_type;

   // Side data carried along the back pipeline
   typedef struct packed {
      logic [63:0]   t;
      logic [63:0]   z;
      logic [63:0]   s;
      scp_flags_type flags;
   } scp_side_type;

   // Constant added after each multiply of the chain
   function automatic logic signed [63:0] mul_addend(input int idx);
      logic signed [63:0] r;
      case (idx)
         1:       r = KC1;
         2:       r = KC2;
         3:       r = KC3;
         4:       r = KC4;
         5:       r = KC5;
         6:       r = ONE62;
         8:       r = ONE62;
         default: r = '0;
      endcase
      return r;
   endfunction

   // Round a Q.60 magnitude to the output format, saturate, then apply the sign
   function automatic logic [31:0] to_out(input logic [63:0] x60, input logic negf);
      localparam int OSH = 60 - OUT_FRAC_BITS;
      logic [63:0] r;
      logic [31:0] m;
      r = (x60 + (64'd1 << (OSH - 1))) >> OSH;
      m = (r > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : r[31:0];
      return negf ? (32'd0 - m) : m;
   endfunction

endpackage

### hdl/scp_front.sv
// Front part: saturates the angle and folds it into [0, pi/4] by symmetry.
// Four register stages with one shared enable; uses scp_pkg.
module scp_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  logic [31:0]          angle,
   output logic                 out_valid,
   input  logic                 out_ready,
   output scp_pkg::scp_item_type out_item
);

   localparam int SH = 58 - scp_pkg::ANGLE_FRAC_BITS;
   localparam int XW = scp_pkg::XW;

   logic                  en;
   logic                  a_vld_ff, b_vld_ff, c_vld_ff, d_vld_ff;
   scp_pkg::scp_fold_type a_ff, a_in, b_ff, b_in, c_ff, c_in;
   scp_pkg::scp_item_type d_ff, d_in;

   // Advance whenever the last stage is empty or the queue takes it
   assign en        = !d_vld_ff || out_ready;
   assign in_ready  = en;
   assign out_valid = d_vld_ff;
   assign out_item  = d_ff;

   // Stage A: magnitude, sign and saturation to [-pi, 3pi]
   always_comb begin
      logic        neg;
      logic [32:0] mag;
      logic [63:0] limit;
      logic [63:0] x;
      neg   = angle[31];
      mag   = neg ? (33'h1_0000_0000 - {1'b0, angle}) : {1'b0, angle};
      limit = neg ? scp_pkg::PI58 : scp_pkg::THREEPI58;
      if ({31'd0, mag} > (limit >> SH) + 64'd1) begin
         x = limit;
      end else begin
         x = {31'd0, mag} << SH;
      end
      if (x > limit) begin
         x = limit;
      end
      a_in.x           = x[XW-1:0];
      a_in.flags.s_neg = neg;
      a_in.flags.c_neg = 1'b0;
      a_in.flags.swap  = 1'b0;
   end

   // Stage B: angles above pi fold back by 2pi
   always_comb begin
      b_in = a_ff;
      if (!a_ff.flags.s_neg && a_ff.x > scp_pkg::PI58[XW-1:0]) begin
         if (a_ff.x >= scp_pkg::TWOPI58[XW-1:0]) begin
            b_in.x = a_ff.x - scp_pkg::TWOPI58[XW-1:0];
         end else begin
            b_in.x           = scp_pkg::TWOPI58[XW-1:0] - a_ff.x;
            b_in.flags.s_neg = 1'b1;
         end
      end
   end

   // Stage C: reflect about pi/2, cosine changes sign
   always_comb begin
      c_in = b_ff;
      if (b_ff.x > scp_pkg::HALFPI58[XW-1:0]) begin
         c_in.x           = scp_pkg::PI58[XW-1:0] - b_ff.x;
         c_in.flags.c_neg = 1'b1;
      end
   end

   // Stage D: above pi/4 the two outputs swap; t goes to Q.62
   always_comb begin
      logic [XW-1:0] x;
      x        = c_ff.x;
      d_in.flags = c_ff.flags;
      if (c_ff.x > scp_pkg::QUARTERPI58[XW-1:0]) begin
         x               = scp_pkg::HALFPI58[XW-1:0] - c_ff.x;
         d_in.flags.swap = 1'b1;
      end
      d_in.t = {x[59:0], 4'b0000};
   end

   // Valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff <= 1'b0;
         b_vld_ff <= 1'b0;
         c_vld_ff <= 1'b0;
         d_vld_ff <= 1'b0;
      end else if (en) begin
         a_vld_ff <= in_valid;
         b_vld_ff <= a_vld_ff;
         c_vld_ff <= b_vld_ff;
         d_vld_ff <= c_vld_ff;
      end
   end

   // Payload
   always_ff @(posedge clock) begin
      if (en) begin
         a_ff <= a_in;
         b_ff <= b_in;
         c_ff <= c_in;
         d_ff <= d_in;
      end
   end

endmodule

### hdl/scp_fifo.sv
// Short queue of folded items between the front and back parts.
// Flip-flop storage, one read port; uses scp_pkg for the item type.
module scp_fifo #(
   parameter int DEPTH = scp_pkg::QUEUE_DEPTH
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  scp_pkg::scp_item_type push_item,
   input  logic                 pop,
   output scp_pkg::scp_item_type head_item,
   output logic                 full,
   output logic                 empty
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   scp_pkg::scp_item_type mem_ff [DEPTH];
   logic [PW-1:0]         wr_ff, wr_in, rd_ff, rd_in;
   logic [CW-1:0]         cnt_ff, cnt_in;

   assign full      = (cnt_ff == CW'(DEPTH));
   assign empty     = (cnt_ff == '0);
   assign head_item = mem_ff[rd_ff];

   // Pointer and count update
   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (push) begin
         wr_in = (wr_ff == PW'(DEPTH - 1)) ? '0 : wr_ff + 1'b1;
      end
      if (pop) begin
         rd_in = (rd_ff == PW'(DEPTH - 1)) ? '0 : rd_ff + 1'b1;
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   // Storage
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= push_item;
      end
   end

endmodule

### hdl/scp_mul.sv
// Three-stage Q.62 multiply: sign-magnitude partial products, sum and
// round-half-up on the magnitude, then sign and a constant addend. Uses scp_pkg.
module scp_mul #(
   parameter logic               NEG    = 1'b0,
   parameter logic signed [63:0] ADDEND = '0
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 en,
   input  logic                 in_valid,
   input  logic signed [63:0]   a,
   input  logic signed [63:0]   b,
   input  scp_pkg::scp_side_type in_side,
   output logic                 out_valid,
   output logic signed [63:0]   result,
   output scp_pkg::scp_side_type out_side
);

   logic                  v1_ff, v2_ff, v3_ff;
   logic                  n1_ff, n2_ff;
   logic [63:0]           p00_ff, p01_ff, p10_ff, p11_ff;
   logic [63:0]           p00_in, p01_in, p10_in, p11_in;
   logic [127:0]          sum_ff, sum_in;
   logic signed [63:0]    res_ff, res_in;
   logic                  n1_in;
   scp_pkg::scp_side_type s1_ff, s2_ff, s3_ff;

   // Stage 1: magnitudes and four 32x32 partial products
   always_comb begin
      logic [63:0] ma;
      logic [63:0] mb;
      ma     = a[63] ? (64'd0 - a) : a;
      mb     = b[63] ? (64'd0 - b) : b;
      n1_in  = a[63] ^ b[63] ^ NEG;
      p00_in = ma[31:0]  * mb[31:0];
      p01_in = ma[31:0]  * mb[63:32];
      p10_in = ma[63:32] * mb[31:0];
      p11_in = ma[63:32] * mb[63:32];
   end

   // Stage 2: full product plus rounding half
   assign sum_in = {64'd0, p00_ff} + {32'd0, p01_ff, 32'd0} + {32'd0, p10_ff, 32'd0}
                 + {p11_ff, 64'd0} + (128'd1 << 61);

   // Stage 3: drop 62 bits, sign, addend
   always_comb begin
      logic [63:0] r;
      r      = sum_ff[125:62];
      res_in = (n2_ff ? (64'd0 - r) : r) + ADDEND;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p00_ff <= p00_in;
         p01_ff <= p01_in;
         p10_ff <= p10_in;
         p11_ff <= p11_in;
         n1_ff  <= n1_in;
         s1_ff  <= in_side;
         sum_ff <= sum_in;
         n2_ff  <= n1_ff;
         s2_ff  <= s1_ff;
         res_ff <= res_in;
         s3_ff  <= s2_ff;
      end
   end

   assign out_valid = v3_ff;
   assign result    = res_ff;
   assign out_side  = s3_ff;

endmodule

### hdl/scp_sqrt.sv
// Pipelined bit-pair square root: floor(sqrt(v * 2^58)), a few pairs per stage.
// Uses scp_pkg for stage counts and the side data type.
module scp_sqrt (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 en,
   input  logic                 in_valid,
   input  logic [63:0]          v,
   input  scp_pkg::scp_side_type in_side,
   output logic                 out_valid,
   output logic [63:0]          root,
   output scp_pkg::scp_side_type out_side
);

   localparam int NS = scp_pkg::SQRT_STAGES;

   logic                  vld_ff  [NS];
   logic [65:0]           rem_ff  [NS];
   logic [63:0]           root_ff [NS];
   logic [127:0]          rad_ff  [NS];
   scp_pkg::scp_side_type side_ff [NS];

   for (genvar st = 0; st < NS; st++) begin : g_stage
      logic                  vld_src;
      logic [65:0]           rem_src, rem_in;
      logic [63:0]           root_src, root_in;
      logic [127:0]          rad_src, rad_in;
      scp_pkg::scp_side_type side_src;

      if (st == 0) begin : g_first
         assign vld_src  = in_valid;
         assign rem_src  = '0;
         assign root_src = '0;
         assign rad_src  = {6'd0, v, 58'd0};
         assign side_src = in_side;
      end else begin : g_next
         assign vld_src  = vld_ff[st-1];
         assign rem_src  = rem_ff[st-1];
         assign root_src = root_ff[st-1];
         assign rad_src  = rad_ff[st-1];
         assign side_src = side_ff[st-1];
      end

      // Restoring steps, one bit pair each
      always_comb begin
         logic [65:0] trial;
         rem_in  = rem_src;
         root_in = root_src;
         rad_in  = rad_src;
         for (int j = 0; j < scp_pkg::SQRT_STEPS; j++) begin
            rem_in = {rem_in[63:0], rad_in[127:126]};
            rad_in = {rad_in[125:0], 2'b00};
            trial  = {root_in, 2'b01};
            if (rem_in >= trial) begin
               rem_in  = rem_in - trial;
               root_in = {root_in[62:0], 1'b1};
            end else begin
               root_in = {root_in[62:0], 1'b0};
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[st] <= 1'b0;
         end else if (en) begin
            vld_ff[st] <= vld_src;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[st]  <= rem_in;
            root_ff[st] <= root_in;
            rad_ff[st]  <= rad_in;
            side_ff[st] <= side_src;
         end
      end
   end

   assign out_valid = vld_ff[NS-1];
   assign root      = root_ff[NS-1];
   assign out_side  = side_ff[NS-1];

endmodule

### hdl/sine_cosine_polynomial.sv
// Top level of the sine/cosine unit: front folding, queue, multiply chain,
// square root and output rounding. Uses scp_pkg, scp_front, scp_fifo, scp_mul, scp_sqrt.
//
//   channel  direction  payload (low bits first)                handshake
//   req_*    in         tdata[31:0] angle, Q5.27 radians         tvalid/tready
//   rsp_*    out        tdata[31:0] cosine, [63:32] sine, Q2.30  tvalid/tready
//
// One angle per cycle is accepted when nothing stalls; each result passes through
// 4 fold stages, the queue, 9 multiplies of 3 stages, 32 root stages and one
// output stage. Reset is synchronous and clears every valid bit and the queue.
// A stalled rsp_tready freezes the back pipeline; the queue lets the front keep
// accepting until it fills.
module sine_cosine_polynomial #(
   parameter int QUEUE_DEPTH = scp_pkg::QUEUE_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] angle
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata    // [31:0] cosine, [63:32] sine
);

   localparam int NM = scp_pkg::MUL_COUNT;

   logic                  f_valid, q_full, q_empty, q_pop, be;
   scp_pkg::scp_item_type f_item, q_item;

   logic                  mv_in   [NM];
   logic                  mv_out  [NM];
   logic signed [63:0]    ma      [NM];
   logic signed [63:0]    mb      [NM];
   logic signed [63:0]    mr      [NM];
   scp_pkg::scp_side_type ms_in   [NM];
   scp_pkg::scp_side_type ms_out  [NM];

   logic signed [63:0]    s_clamp, v_clamp;
   logic                  r_valid;
   logic [63:0]           r_root;
   scp_pkg::scp_side_type r_side;

   logic                  out_vld_ff;
   logic [63:0]           out_data_ff, out_data_in;

   // Front part
   scp_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .angle     (req_tdata),
      .out_valid (f_valid),
      .out_ready (!q_full),
      .out_item  (f_item)
   );

   // Queue between the parts
   scp_fifo #(
      .DEPTH (QUEUE_DEPTH)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (f_valid && !q_full),
      .push_item (f_item),
      .pop       (q_pop),
      .head_item (q_item),
      .full      (q_full),
      .empty     (q_empty)
   );

   // Back pipeline moves unless the output holds an item nobody takes
   assign be    = !out_vld_ff || rsp_tready;
   assign q_pop = !q_empty && be;

   assign s_clamp = mr[7][63] ? '0 : mr[7];
   assign v_clamp = mr[8][63] ? '0 : mr[8];

   // Multiply chain: z = t*t, Horner steps in z, s = p*t, then 1 - s*s
   for (genvar k = 0; k < NM; k++) begin : g_mul
      if (k == 0) begin : g_z
         assign mv_in[k]       = !q_empty;
         assign ma[k]          = q_item.t;
         assign mb[k]          = q_item.t;
         assign ms_in[k].t     = q_item.t;
         assign ms_in[k].z     = '0;
         assign ms_in[k].s     = '0;
         assign ms_in[k].flags = q_item.flags;
      end else if (k == 1) begin : g_first
         assign mv_in[k] = mv_out[k-1];
         assign ma[k]    = mr[k-1];
         assign mb[k]    = scp_pkg::KC0;
         always_comb begin
            ms_in[k]   = ms_out[k-1];
            ms_in[k].z = mr[k-1];
         end
      end else if (k < 7) begin : g_horner
         assign mv_in[k] = mv_out[k-1];
         assign ma[k]    = mr[k-1];
         assign mb[k]    = ms_out[k-1].z;
         assign ms_in[k] = ms_out[k-1];
      end else if (k == 7) begin : g_sine
         assign mv_in[k] = mv_out[k-1];
         assign ma[k]    = mr[k-1];
         assign mb[k]    = ms_out[k-1].t;
         assign ms_in[k] = ms_out[k-1];
      end else begin : g_comp
         assign mv_in[k] = mv_out[k-1];
         assign ma[k]    = s_clamp;
         assign mb[k]    = s_clamp;
         always_comb begin
            ms_in[k]   = ms_out[k-1];
            ms_in[k].s = s_clamp;
         end
      end

      scp_mul #(
         .NEG    (k == 8),
         .ADDEND (scp_pkg::mul_addend(k))
      ) u_mul (
         .clock     (clock),
         .reset     (reset),
         .en        (be),
         .in_valid  (mv_in[k]),
         .a         (ma[k]),
         .b         (mb[k]),
         .in_side   (ms_in[k]),
         .out_valid (mv_out[k]),
         .result    (mr[k]),
         .out_side  (ms_out[k])
      );
   end

   // Companion value
   scp_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (be),
      .in_valid  (mv_out[NM-1]),
      .v         (v_clamp),
      .in_side   (ms_out[NM-1]),
      .out_valid (r_valid),
      .root      (r_root),
      .out_side  (r_side)
   );

   // Output stage: restore order and signs, round to the output format
   always_comb begin
      logic [63:0] s60;
      s60 = (r_side.s + 64'd2) >> 2;
      if (r_side.flags.swap) begin
         out_data_in = {scp_pkg::to_out(r_root, r_side.flags.s_neg),
                        scp_pkg::to_out(s60, r_side.flags.c_neg)};
      end else begin
         out_data_in = {scp_pkg::to_out(s60, r_side.flags.s_neg),
                        scp_pkg::to_out(r_root, r_side.flags.c_neg)};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (be) begin
         out_vld_ff <= r_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (be) begin
         out_data_ff <= out_data_in;
      end
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = out_data_ff;

endmodule

### dv/tb_top.sv
// Self-checking testbench for sine_cosine_polynomial: drives angles, predicts
// cosine/sine in exact integer arithmetic, checks results in order. Uses scp_pkg.

// Scoreboard: predicts cosine/sine per accepted angle and checks results in order
class trig_scoreboard;
   bit [63:0] pending_q[$];
   int        errors;

   // Magnitude product rounded to nearest at bit 62
   static function bit [63:0] umul_q62(bit [63:0] a, bit [63:0] b);
      bit [127:0] p;
      p = {64'd0, a} * {64'd0, b};
      p = (p + (128'd1 << 61)) >> 62;
      return p[63:0];
   endfunction

   static function bit signed [63:0] smul_q62(bit signed [63:0] a, bit signed [63:0] b);
      bit [63:0] ua, ub, r;
      ua = a[63] ? -a : a;
      ub = b[63] ? -b : b;
      r  = umul_q62(ua, ub);
      return (a[63] != b[63]) ? -r : r;
   endfunction

   // Floor square root of a 128-bit radicand
   static function bit [63:0] root_floor(bit [127:0] rad);
      bit [127:0] root, rem, trial;
      root = 0;
      rem  = 0;
      for (int i = 63; i >= 0; i--) begin
         rem   = (rem << 2) | ((rad >> (2 * i)) & 128'd3);
         trial = (root << 2) | 128'd1;
         if (rem >= trial) begin
            rem  = rem - trial;
            root = (root << 1) | 128'd1;
         end else begin
            root = root << 1;
         end
      end
      return root[63:0];
   endfunction

   // Q.60 magnitude to output format with rounding, saturation and sign
   static function bit [31:0] q60_to_port(bit [63:0] x60, bit negf);
      int        sh;
      bit [63:0] r;
      sh = 60 - scp_pkg::OUT_FRAC_BITS;
      r  = (x60 + (64'd1 << (sh - 1))) >> sh;
      if (r > 64'h7FFF_FFFF) r = 64'h7FFF_FFFF;
      return negf ? (32'd0 - r[31:0]) : r[31:0];
   endfunction

   static function bit [63:0] cos_sin_of(bit [31:0] angle);
      bit                neg, c_neg, swap;
      bit [32:0]         mag;
      bit [63:0]         lim, x, s60, root;
      bit signed [63:0]  t, z, acc, s, v;
      int                sh;
      bit [31:0]         cv, sv;
      sh    = 58 - scp_pkg::ANGLE_FRAC_BITS;
      neg   = angle[31];
      mag   = neg ? (33'h1_0000_0000 - {1'b0, angle}) : {1'b0, angle};
      lim   = neg ? scp_pkg::PI58 : scp_pkg::THREEPI58;
      c_neg = 0;
      swap  = 0;
      // saturate to [-pi, 3pi]
      if ({31'd0, mag} > (lim >> sh) + 64'd1) x = lim;
      else x = {31'd0, mag} << sh;
      if (x > lim) x = lim;
      // fold into [0, pi/4]
      if (!neg && x > scp_pkg::PI58) begin
         if (x >= scp_pkg::TWOPI58) x = x - scp_pkg::TWOPI58;
         else begin
            x   = scp_pkg::TWOPI58 - x;
            neg = 1;
         end
      end
      if (x > scp_pkg::HALFPI58) begin
         x     = scp_pkg::PI58 - x;
         c_neg = 1;
      end
      if (x > scp_pkg::QUARTERPI58) begin
         x    = scp_pkg::HALFPI58 - x;
         swap = 1;
      end
      // odd Horner polynomial
      t   = x << 4;
      z   = smul_q62(t, t);
      acc = smul_q62(z, scp_pkg::KC0);
      acc = smul_q62(acc + scp_pkg::KC1, z);
      acc = smul_q62(acc + scp_pkg::KC2, z);
      acc = smul_q62(acc + scp_pkg::KC3, z);
      acc = smul_q62(acc + scp_pkg::KC4, z);
      acc = smul_q62(acc + scp_pkg::KC5, z);
      s   = smul_q62(acc + scp_pkg::ONE62, t);
      if (s < 0) s = 0;
      v = scp_pkg::ONE62 - smul_q62(s, s);
      if (v < 0) v = 0;
      root = root_floor({64'd0, v} << 58);
      s60  = (s + 64'd2) >> 2;
      if (swap) begin
         cv = q60_to_port(s60, c_neg);
         sv = q60_to_port(root, neg);
      end else begin
         cv = q60_to_port(root, c_neg);
         sv = q60_to_port(s60, neg);
      end
      return {sv, cv};
   endfunction

   function void note_angle(bit [31:0] angle);
      pending_q.push_back(cos_sin_of(angle));
   endfunction

   function void check_result(bit [63:0] data);
      bit [63:0] exp_d;
      if (pending_q.size() == 0) begin
         $display("%0t: unexpected result cos=%h sin=%h", $time, data[31:0], data[63:32]);
         errors++;
         return;
      end
      exp_d = pending_q.pop_front();
      if (exp_d[31:0] !== data[31:0]) begin
         $display("%0t: cosine expected %h actual %h", $time, exp_d[31:0], data[31:0]);
         errors++;
      end
      if (exp_d[63:32] !== data[63:32]) begin
         $display("%0t: sine expected %h actual %h", $time, exp_d[63:32], data[63:32]);
         errors++;
      end
   endfunction
endclass

module tb_top;

   localparam int PI_A  = 421657428;
   localparam int HP_A  = 210828714;
   localparam int QP_A  = 105414357;
   localparam int TP_A  = 843314856;
   localparam int TRP_A = 1264972284;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_tvalid = 0;
   logic        req_tready;
   logic [31:0] req_tdata = 0;   // [31:0] angle
   logic        rsp_tvalid;
   logic        rsp_tready = 0;
   logic [63:0] rsp_tdata;       // [31:0] cosine, [63:32] sine

   trig_scoreboard sb = new();
   int  send_idle_pct = 21;
   int  recv_idle_pct = 46;
   int  hold_cycles   = 0;

   sine_cosine_polynomial dut (.*);

   always #2 clock = ~clock;

   // Accepted items on both channels
   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready) sb.note_angle(req_tdata);
      if (!reset && rsp_tvalid && rsp_tready) sb.check_result(rsp_tdata);
   end

   // Receiver: random stalls, or a long hold-off when requested
   always @(posedge clock) begin
      if (hold_cycles > 0) begin
         hold_cycles <= hold_cycles - 1;
         rsp_tready  <= 0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   task automatic send_angle(bit [31:0] a);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 0;
         @(posedge clock);
      end
      req_tvalid <= 1;
      req_tdata  <= a;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic wait_drained();
      while (sb.pending_q.size() != 0) @(posedge clock);
   endtask

   function automatic bit [31:0] random_angle();
      int pick, base;
      pick = $urandom_range(99);
      if (pick < 10) return $urandom;
      if (pick < 35) begin
         // near a fold or swap point
         case ($urandom_range(7))
            0: base = -PI_A;
            1: base = -HP_A;
            2: base = 0;
            3: base = QP_A;
            4: base = HP_A;
            5: base = PI_A;
            6: base = TP_A;
            default: base = TRP_A;
         endcase
         return base + $signed($urandom_range(8)) - 4;
      end
      return $signed($urandom_range(TRP_A + PI_A)) - PI_A;
   endfunction

   initial begin
      int directed[$];
      directed = '{0, 1, -1, PI_A, PI_A + 1, -PI_A, -PI_A - 1, HP_A, HP_A + 1, -HP_A,
                   QP_A, QP_A + 1, -QP_A, TP_A, TP_A - 1, TP_A + 1, TRP_A, TRP_A + 1,
                   TRP_A + 2, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_0000, 32'h5555_5555,
                   32'hAAAA_AAAA};
      repeat (5) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      foreach (directed[i]) send_angle(directed[i]);
      // sender pause until the pipeline is empty
      req_tvalid <= 0;
      wait_drained();
      for (int phase = 0; phase < 3; phase++) begin
         send_idle_pct = (phase == 0) ? 21 : (phase == 1) ? 46 : 0;
         recv_idle_pct = (phase == 0) ? 46 : (phase == 1) ? 21 : 0;
         for (int n = 0; n < 500; n++) begin
            if (n == 200 && phase != 1) hold_cycles = 300;
            if (n == 400 && phase == 2) send_idle_pct = 0;
            send_angle(random_angle());
         end
      end
      req_tvalid <= 0;
      wait_drained();
      repeat (100) @(posedge clock);
      if (sb.errors == 0 && sb.pending_q.size() == 0)
         $display("sine_cosine_polynomial test passed");
      else
         $display("sine_cosine_polynomial test failed");
      $finish;
   end

   // Watchdog
   initial begin
      #4000000;
      $display("sine_cosine_polynomial test failed");
      $finish;
   end
endmodule
